### hw/rtl/np4biw_pkg.sv
// Package for the blended interpolation weight pipeline.
// Holds fixed-point constants, register addresses and the rounding helper.
// No dependencies.
package np4biw_pkg;

  localparam int FracBitsDefault = 16;
  localparam int CoordW = 18;
  localparam int CoefW = 18;
  localparam int WeightW = 19;
  localparam int AddrW = 4;

  localparam logic [AddrW-1:0] RegCoefLeft  = 4'd0;
  localparam logic [AddrW-1:0] RegCoefMid   = 4'd4;
  localparam logic [AddrW-1:0] RegCoefRight = 4'd8;

  localparam longint S31 = 64'sd960383883;
  localparam longint Two31 = 64'sd2147483648;

  function automatic longint rnd_c(input longint v, input int k);
    longint w;
    w = v + (64'sd1 <<< (k - 1));
    return w >>> k;
  endfunction

endpackage

### hw/rtl/np4biw_mul.sv
// Registered signed fixed-point multiply with round half up.
// Does not use np4biw_pkg; all widths are passed in as parameters.
// The result is registered and advances when en is high.
module np4biw_mul #(
  parameter int AW = 40,
  parameter int BW = 40,
  parameter int SH = 16,
  parameter int RW = 48
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [RW-1:0] r
);
  logic signed [AW+BW-1:0] prod;
  logic signed [AW+BW:0] sum;
  assign prod = a * b;
  assign sum = {prod[AW+BW-1], prod} + ((AW+BW+1)'(1) <<< (SH - 1));
  always_ff @(posedge clk) begin
    if (en) begin
      r <= RW'(sum >>> SH);
    end
  end
endmodule

### hw/rtl/np4_blended_interp_weights_top.sv
// Top level of the blended interpolation weight pipeline.
// Uses np4biw_pkg and np4biw_mul.
//
// channel | dir | fields
// s_axis  | in  | tdata: coord[17:0]
// m_axis  | out | tdata: weight_0..weight_3, 19 bits each, lowest first
// apb     | cfg | coef_left @0, coef_mid @4, coef_right @8
//
// Seven register stages; one item per cycle while the output is not stalled.
// The whole pipeline advances when the output register is empty or taken.
// rst clears valid bits and restores the coefficients to 65536, one at the default FRAC_BITS.
module np4_blended_interp_weights_top #(
  parameter int FRAC_BITS = np4biw_pkg::FracBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // coord[17:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // weight_0, weight_1, weight_2, weight_3
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [np4biw_pkg::AddrW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int W = FRAC_BITS + 24;
  localparam int MW = FRAC_BITS + 8;
  localparam int NS = 7;
  localparam longint One = 64'sd1 <<< FRAC_BITS;
  localparam longint SC = np4biw_pkg::rnd_c(np4biw_pkg::S31, 31 - FRAC_BITS);
  localparam longint R5 = np4biw_pkg::rnd_c(5 * np4biw_pkg::S31, 31 - FRAC_BITS);
  localparam longint K1 = np4biw_pkg::rnd_c(5 * np4biw_pkg::Two31
                                            + 25 * np4biw_pkg::S31, 34 - FRAC_BITS);
  localparam longint K2 = np4biw_pkg::rnd_c(25 * np4biw_pkg::S31
                                            - 5 * np4biw_pkg::Two31, 34 - FRAC_BITS);
  localparam longint TK = np4biw_pkg::rnd_c(5 * np4biw_pkg::Two31
                                            + 5 * np4biw_pkg::S31, 32 - FRAC_BITS);
  localparam longint Fifth = (2 * One + 5) / 10;
  localparam longint WMax = 64'sd262143;
  localparam longint WMin = -64'sd262144;

  typedef logic signed [W-1:0] val_t;

  logic signed [np4biw_pkg::CoefW-1:0] coef_left, coef_mid, coef_right;
  logic [NS-1:0] vld;
  logic adv;

  assign pready = 1'b1;
  assign adv = !vld[NS-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_left <= 18'sd65536;
      coef_mid <= 18'sd65536;
      coef_right <= 18'sd65536;
      vld <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        unique case (paddr)
          np4biw_pkg::RegCoefLeft:  coef_left <= pwdata[17:0];
          np4biw_pkg::RegCoefMid:   coef_mid <= pwdata[17:0];
          np4biw_pkg::RegCoefRight: coef_right <= pwdata[17:0];
          default: ;
        endcase
      end
      if (adv) begin
        vld <= {vld[NS-2:0], s_axis_tvalid};
      end
    end
  end

  always_comb begin
    unique case (paddr)
      np4biw_pkg::RegCoefLeft:  prdata = 32'(coef_left);
      np4biw_pkg::RegCoefMid:   prdata = 32'(coef_mid);
      np4biw_pkg::RegCoefRight: prdata = 32'(coef_right);
      default: prdata = '0;
    endcase
  end

  function automatic val_t r3(input val_t v);
    return (v + val_t'(4)) >>> 3;
  endfunction

  // stage 1: clamp, fold
  logic signed [17:0] xin;
  val_t x1, u1;
  logic pos2, far2, pos3, far3, pos4, far4, pos5, far5, pos6, far6;
  assign xin = s_axis_tdata[17:0];
  always_ff @(posedge clk) begin
    if (adv) begin
      if (W'(xin) > val_t'(One)) x1 <= val_t'(One);
      else if (W'(xin) < -val_t'(One)) x1 <= -val_t'(One);
      else x1 <= W'(xin);
    end
  end
  always_comb begin
    u1 = x1[W-1] ? x1 : -x1;
  end
  logic pos1c, far1c;
  assign pos1c = x1 > 0;
  assign far1c = -u1 > val_t'(SC);

  // stage 2: v, h, a = (1+u)(s-u), b = (1+u)(s+u), t
  val_t u2, v2, h2, pa2, pb2, t2r;
  always_ff @(posedge clk) begin
    if (adv) begin
      u2 <= u1; pos2 <= pos1c; far2 <= far1c;
    end
  end
  np4biw_mul #(MW, MW, FRAC_BITS, W) m_v (clk, adv, MW'(u1), MW'(u1), v2);
  np4biw_mul #(MW, MW, FRAC_BITS, W) m_h (clk, adv, MW'(val_t'(R5)), MW'(u1), h2);
  np4biw_mul #(MW, MW, FRAC_BITS, W) m_pa (clk, adv, MW'(val_t'(One) + u1),
                                           MW'(val_t'(SC) - u1), pa2);
  np4biw_mul #(MW, MW, FRAC_BITS, W) m_pb (clk, adv, MW'(val_t'(One) + u1),
                                           MW'(val_t'(SC) + u1), pb2);
  np4biw_mul #(MW, MW, FRAC_BITS, W) m_t (clk, adv, MW'(val_t'(One) + u1),
                                          MW'(val_t'(TK)), t2r);

  // stage 3: L products, P1, P2, t*t, t*e
  val_t t2, d2, g2;
  assign t2 = t2r - val_t'(One);
  assign d2 = v2 - val_t'(Fifth);
  assign g2 = val_t'(One) - v2;
  val_t m0_3, m3_3, m1_3, m2_3, p1_3, p2_3, tt3, te3, d3;
  logic signed [19:0] e2, f2;
  assign e2 = 20'(coef_right) - 20'(coef_left);
  assign f2 = 20'(coef_left) - (20'(coef_mid) <<< 1) + 20'(coef_right);
  np4biw_mul #(MW, MW, FRAC_BITS, W) m_l0 (clk, adv, MW'(d2), MW'(val_t'(One) - u2), m0_3);
  np4biw_mul #(MW, MW, FRAC_BITS, W) m_l3 (clk, adv, MW'(d2), MW'(val_t'(One) + u2), m3_3);
  np4biw_mul #(MW, MW, FRAC_BITS, W) m_l1 (clk, adv, MW'(g2), MW'(val_t'(One) - h2), m1_3);
  np4biw_mul #(MW, MW, FRAC_BITS, W) m_l2 (clk, adv, MW'(g2), MW'(val_t'(One) + h2), m2_3);
  np4biw_mul #(MW, MW, FRAC_BITS, W) m_p1 (clk, adv, MW'(pa2), MW'(val_t'(K1)), p1_3);
  np4biw_mul #(MW, MW, FRAC_BITS, W) m_p2 (clk, adv, MW'(pb2), MW'(val_t'(K2)), p2_3);
  np4biw_mul #(MW, MW, FRAC_BITS, W) m_tt (clk, adv, MW'(t2), MW'(t2), tt3);
  np4biw_mul #(MW, 20, FRAC_BITS + 1, W) m_te (clk, adv, MW'(t2), e2, te3);
  logic signed [19:0] f3;
  always_ff @(posedge clk) begin
    if (adv) begin
      d3 <= d2; f3 <= f2; pos3 <= pos2; far3 <= far2;
    end
  end

  // stage 4: L values, P0, quadratic term
  val_t l4 [4];
  val_t p4 [4];
  val_t tef4;
  val_t q4;
  logic signed [17:0] cm4;
  always_ff @(posedge clk) begin
    if (adv) begin
      l4[0] <= r3(5 * m0_3);
      l4[1] <= r3(5 * m1_3);
      l4[2] <= r3(5 * m2_3);
      l4[3] <= r3(5 * m3_3);
      p4[0] <= (5 * d3 + val_t'(2)) >>> 2;
      p4[1] <= p1_3;
      p4[2] <= p2_3;
      p4[3] <= '0;
      tef4 <= te3;
      cm4 <= coef_mid;
      pos4 <= pos3; far4 <= far3;
    end
  end
  np4biw_mul #(MW, 20, FRAC_BITS + 1, W) m_q (clk, adv, MW'(tt3), f3, q4);

  // stage 5: a
  val_t a5;
  val_t l5 [4];
  val_t df5 [4];
  always_ff @(posedge clk) begin
    if (adv) begin
      a5 <= W'(cm4) + tef4 + q4;
      for (int i = 0; i < 4; i++) begin
        l5[i] <= l4[i];
        df5[i] <= p4[i] - l4[i];
      end
      pos5 <= pos4; far5 <= far4;
    end
  end

  // stage 6: a*(P-L)
  val_t bl6 [4];
  val_t l6 [4];
  for (genvar i = 0; i < 4; i++) begin : g_bl
    np4biw_mul #(MW, MW, FRAC_BITS, W) m_b (clk, adv, MW'(a5), MW'(df5[i]), bl6[i]);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) l6[i] <= l5[i];
      pos6 <= pos5; far6 <= far5;
    end
  end

  // stage 7: select, mirror, saturate
  val_t y6 [4];
  logic [18:0] o7 [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      y6[i] = far6 ? l6[i] + bl6[i] : l6[i];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        if (y6[pos6 ? 3 - i : i] > val_t'(WMax)) o7[i] <= 19'(WMax);
        else if (y6[pos6 ? 3 - i : i] < val_t'(WMin)) o7[i] <= 19'(WMin);
        else o7[i] <= y6[pos6 ? 3 - i : i][18:0];
      end
    end
  end
  assign m_axis_tdata = {4'b0, o7[3], o7[2], o7[1], o7[0]};
endmodule

### test/tb_top.sv
// Testbench for np4_blended_interp_weights_top: drives coordinates over the stream
// input, predicts the four blended weights in fixed point and checks each output item.
// Depends on np4biw_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_top;
  import np4biw_pkg::*;

  localparam int FB = FracBitsDefault;
  localparam longint ONE = 64'sd1 <<< FB;
  localparam longint WMAX = 262143;
  localparam longint WMIN = -262144;
  localparam int WDOG = 5000;

  typedef struct packed {
    logic [18:0] w3;
    logic [18:0] w2;
    logic [18:0] w1;
    logic [18:0] w0;
  } weights_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [23:0] s_axis_tdata = '0;    // coord[17:0]
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;         // weight_0, weight_1, weight_2, weight_3
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  longint coef_l = 65536, coef_m = 65536, coef_r = 65536;
  weights_t weights_due[$];
  int errors = 0;
  int items_sent = 0;
  int items_checked = 0;
  int idle_cnt = 0;
  bit stall_on = 1'b1;

  np4_blended_interp_weights_top uut (.*);

  always #5 clk = ~clk;

  function automatic longint rnd_half_up(longint v, int k);
    longint w;
    w = v + (64'sd1 <<< (k - 1));
    return w >>> k;
  endfunction

  function automatic longint fmul(longint a, longint b);
    return rnd_half_up(a * b, FB);
  endfunction

  function automatic weights_t blend_weights(logic [17:0] raw);
    longint s, r5, k1, k2, tk, fifth, x, ax, u, v, d, g, h, t, e, f, a, y;
    longint lw[4], pw[4], w[4];
    weights_t res;
    s = rnd_half_up(S31, 31 - FB);
    r5 = rnd_half_up(5 * S31, 31 - FB);
    k1 = rnd_half_up(5 * Two31 + 25 * S31, 34 - FB);
    k2 = rnd_half_up(25 * S31 - 5 * Two31, 34 - FB);
    tk = rnd_half_up(5 * Two31 + 5 * S31, 32 - FB);
    fifth = (2 * ONE + 5) / 10;
    x = longint'($signed(raw));
    if (x > ONE) x = ONE;
    if (x < -ONE) x = -ONE;
    ax = (x < 0) ? -x : x;
    u = -ax;
    v = fmul(u, u);
    d = v - fifth;
    g = ONE - v;
    h = fmul(r5, u);
    lw[0] = rnd_half_up(5 * fmul(d, ONE - u), 3);
    lw[3] = rnd_half_up(5 * fmul(d, ONE + u), 3);
    lw[1] = rnd_half_up(5 * fmul(g, ONE - h), 3);
    lw[2] = rnd_half_up(5 * fmul(g, ONE + h), 3);
    if (ax > s) begin
      pw[0] = rnd_half_up(5 * d, 2);
      pw[1] = fmul(fmul(ONE + u, s - u), k1);
      pw[2] = fmul(fmul(ONE + u, s + u), k2);
      pw[3] = 0;
      t = fmul(ONE + u, tk) - ONE;
      e = coef_r - coef_l;
      f = coef_l - 2 * coef_m + coef_r;
      a = coef_m + rnd_half_up(t * e, FB + 1) + rnd_half_up(fmul(t, t) * f, FB + 1);
      for (int i = 0; i < 4; i++) w[i] = lw[i] + fmul(a, pw[i] - lw[i]);
    end else begin
      for (int i = 0; i < 4; i++) w[i] = lw[i];
    end
    for (int i = 0; i < 4; i++) begin
      y = (x > 0) ? w[3 - i] : w[i];
      if (y > WMAX) y = WMAX;
      if (y < WMIN) y = WMIN;
      case (i)
        0: res.w0 = y[18:0];
        1: res.w1 = y[18:0];
        2: res.w2 = y[18:0];
        default: res.w3 = y[18:0];
      endcase
    end
    return res;
  endfunction

  task automatic write_coef(logic [AddrW-1:0] addr, logic [17:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr;
    pwdata <= {{14{val[17]}}, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (addr)
      RegCoefLeft: coef_l = longint'($signed(val));
      RegCoefMid: coef_m = longint'($signed(val));
      RegCoefRight: coef_r = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic send_coord(logic [17:0] c, bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, c};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    weights_due.push_back(blend_weights(c));
    items_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (weights_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_coefs(logic [17:0] l, logic [17:0] m, logic [17:0] r);
    drain();
    write_coef(RegCoefLeft, l);
    write_coef(RegCoefMid, m);
    write_coef(RegCoefRight, r);
  endtask

  function automatic logic [17:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 18'($urandom_range(0, 262143));
      1: return 18'($urandom_range(29300 - 8, 29300 + 8)) ^ {18{$urandom_range(0, 1) == 1}};
      default: return 18'(int'($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  task automatic test_directed();
    logic [17:0] pts[$] = '{18'h20000, 18'h1FFFF, -18'sd65537, -18'sd65536, 18'd65536,
      18'd65537, 18'd0, 18'd1, -18'sd1, 18'd29309, 18'd29310, -18'sd29309,
      -18'sd29310, 18'd29308, 18'd32768, -18'sd32768, 18'h15555, 18'h2AAAA};
    foreach (pts[i]) send_coord(pts[i], 1'b0);
  endtask

  task automatic test_coef_sets();
    logic [17:0] sets[5][3] = '{'{18'h20000, 18'h20000, 18'h20000},
      '{18'h1FFFF, 18'h1FFFF, 18'h1FFFF}, '{18'h1FFFF, 18'h20000, 18'h1FFFF},
      '{18'h20000, 18'h1FFFF, 18'h0}, '{18'd0, 18'd0, 18'd0}};
    foreach (sets[k]) begin
      set_coefs(sets[k][0], sets[k][1], sets[k][2]);
      repeat (40) send_coord(rand_coord(), 1'b1);
    end
  endtask

  task automatic test_random();
    for (int k = 0; k < 5; k++) begin
      set_coefs(18'($urandom), 18'($urandom), 18'($urandom));
      repeat (100) send_coord(rand_coord(), 1'b1);
    end
    drain();
    stall_on = 1'b0;
    set_coefs(18'd65536, 18'd65536, 18'd65536);
    repeat (80) send_coord(rand_coord(), 1'b0);
  endtask

  always @(posedge clk) begin
    if (!rst) m_axis_tready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
  end

  always @(posedge clk) begin
    weights_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[75:0];
      items_checked++;
      if (weights_due.size() == 0) begin
        $error("output item with nothing expected: %h", m_axis_tdata);
        errors++;
      end else begin
        want = weights_due.pop_front();
        if (got.w0 !== want.w0) begin
          $error("weight_0 expected %h got %h", want.w0, got.w0); errors++;
        end
        if (got.w1 !== want.w1) begin
          $error("weight_1 expected %h got %h", want.w1, got.w1); errors++;
        end
        if (got.w2 !== want.w2) begin
          $error("weight_2 expected %h got %h", want.w2, got.w2); errors++;
        end
        if (got.w3 !== want.w3) begin
          $error("weight_3 expected %h got %h", want.w3, got.w3); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt > WDOG) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_coef_sets();
    test_random();
    drain();
    if (weights_due.size() != 0) errors++;
    $display("Sent %0d coordinates, checked %0d weight sets over 12 coefficient settings.",
      items_sent, items_checked);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
